/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/b2b_pkg.sv */
// ----------------------------------------------------------------------------
// b2b_pkg
// types, constants and helper functions for the blake2b-256 core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2b_pkg;

    localparam int unsigned ROUNDS = 12;
    localparam logic [7:0] BLOCK_BYTES = 8'd128;
    localparam logic [3:0] WORD_BYTES = 4'd8;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // fanout 1, depth 1, 32-byte digest
    localparam logic [63:0] PARAM_WORD = 64'h0000000001010020;

    localparam logic [3:0] SIGMA [0:11][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_COUNT,
        OP_INIT,
        OP_ROUND,
        OP_FOLD,
        OP_RESET
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_COUNT,
        S_INIT,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       take;      // input transaction this cycle
        logic       final_blk;
        logic [3:0] rnd;
        logic [2:0] g;
        logic [2:0] phase;
        logic [1:0] word_sel;
    } cmd_t;

    typedef struct packed {
        logic fill_full;
        logic count_zero;
    } sts_t;

    // column and diagonal indices of mixing step g
    function automatic logic [3:0] idx_a(input logic [2:0] g);
        idx_a = {2'b00, g[1:0]};
    endfunction

    function automatic logic [3:0] idx_b(input logic [2:0] g);
        logic [1:0] s;
        s = g[1:0] + {1'b0, g[2]};
        idx_b = {2'b01, s};
    endfunction

    function automatic logic [3:0] idx_c(input logic [2:0] g);
        logic [1:0] s;
        s = g[1:0] + {g[2], 1'b0};
        idx_c = {2'b10, s};
    endfunction

    function automatic logic [3:0] idx_d(input logic [2:0] g);
        logic [1:0] s;
        s = g[1:0] + {g[2], g[2]};
        idx_d = {2'b11, s};
    endfunction

endpackage

/* hdl/b2b_ram.sv */
// ----------------------------------------------------------------------------
// b2b_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2b_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/b2b_datapath.sv */
// ----------------------------------------------------------------------------
// b2b_datapath
// chain value, counter, block buffer and the shared mixing unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2b_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  b2b_pkg::cmd_t cmd,
    input  logic [63:0]   data_word,
    input  logic [3:0]    byte_count,
    input  logic          last,
    output b2b_pkg::sts_t sts,
    output logic [63:0]   digest_word
);

    logic [63:0] chain_reg [0:7];
    logic [63:0] chain_next [0:7];
    logic [127:0] counter_reg, counter_next;
    logic [7:0]  fill_reg, fill_next;
    logic [63:0] v_reg [0:15];
    logic [63:0] v_next [0:15];
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        mvalid_reg;
    logic        mvalid_next;

    logic [3:0]  sat_count;
    logic [63:0] masked_word;
    logic [3:0]  rd_addr;
    logic [63:0] rd_data;
    logic [63:0] m;
    logic [3:0]  ia, ib, ic, id;
    logic [63:0] va, vb, vc, vd;
    logic [63:0] dn, cn, bn;
    logic [7:0]  add_amt;

    // saturate byte count; non-final items always carry eight bytes
    always_comb
    begin
        if (!last || byte_count > b2b_pkg::WORD_BYTES)
        begin
            sat_count = b2b_pkg::WORD_BYTES;
        end
        else
        begin
            sat_count = byte_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            word_reg  <= data_word;
            count_reg <= sat_count;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked_word[i*8 +: 8] = (4'(i) < count_reg) ? word_reg[i*8 +: 8] : 8'h00;
        end
    end

    assign sts.fill_full  = (fill_reg == b2b_pkg::BLOCK_BYTES);
    assign sts.count_zero = (count_reg == 4'd0);

    assign rd_addr = b2b_pkg::SIGMA[cmd.rnd][{cmd.g, cmd.phase[1]}];

    b2b_ram #(
        .WIDTH (64),
        .DEPTH (16)
    ) u_buf (
        .clk     (clk),
        .wr_en   (cmd.op == b2b_pkg::OP_WRITE),
        .wr_addr (fill_reg[6:3]),
        .wr_data (masked_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // words past the fill level read as zero padding
    assign mvalid_next = ({1'b0, rd_addr, 3'b000} < fill_reg);
    assign m = mvalid_reg ? rd_data : 64'h0;

    assign ia = b2b_pkg::idx_a(cmd.g);
    assign ib = b2b_pkg::idx_b(cmd.g);
    assign ic = b2b_pkg::idx_c(cmd.g);
    assign id = b2b_pkg::idx_d(cmd.g);
    assign va = v_reg[ia];
    assign vb = v_reg[ib];
    assign vc = v_reg[ic];
    assign vd = v_reg[id];

    always_comb
    begin
        if (cmd.phase == 3'd2)
        begin
            dn = {vd[31:0] ^ va[31:0], vd[63:32] ^ va[63:32]};
            cn = vc + dn;
            bn = {(vb[23:0] ^ cn[23:0]), (vb[63:24] ^ cn[63:24])};
        end
        else
        begin
            dn = {vd[15:0] ^ va[15:0], vd[63:16] ^ va[63:16]};
            cn = vc + dn;
            bn = {(vb[62:0] ^ cn[62:0]), (vb[63] ^ cn[63])};
        end
    end

    assign add_amt = cmd.final_blk ? fill_reg : b2b_pkg::BLOCK_BYTES;

    always_comb
    begin
        chain_next   = chain_reg;
        counter_next = counter_reg;
        fill_next    = fill_reg;
        v_next       = v_reg;
        unique case (cmd.op)
            b2b_pkg::OP_WRITE:
            begin
                fill_next = fill_reg + {4'd0, count_reg};
            end
            b2b_pkg::OP_COUNT:
            begin
                counter_next = counter_reg + {120'd0, add_amt};
            end
            b2b_pkg::OP_INIT:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_next[i]     = chain_reg[i];
                    v_next[i + 8] = b2b_pkg::IV[i];
                end
                v_next[12] = b2b_pkg::IV[4] ^ counter_reg[63:0];
                v_next[13] = b2b_pkg::IV[5] ^ counter_reg[127:64];
                v_next[14] = cmd.final_blk ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
            end
            b2b_pkg::OP_ROUND:
            begin
                case (cmd.phase) inside
                    3'd1, 3'd3:
                    begin
                        v_next[ia] = va + vb + m;
                    end
                    3'd2, 3'd4:
                    begin
                        v_next[id] = dn;
                        v_next[ic] = cn;
                        v_next[ib] = bn;
                    end
                    default:
                    begin
                    end
                endcase
            end
            b2b_pkg::OP_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                end
                if (!cmd.final_blk)
                begin
                    fill_next = 8'd0;
                end
            end
            b2b_pkg::OP_RESET:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = b2b_pkg::IV[i];
                end
                chain_next[0] = b2b_pkg::IV[0] ^ b2b_pkg::PARAM_WORD;
                counter_next  = 128'd0;
                fill_next     = 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= b2b_pkg::IV[i];
            end
            chain_reg[0] <= b2b_pkg::IV[0] ^ b2b_pkg::PARAM_WORD;
            counter_reg  <= 128'd0;
            fill_reg     <= 8'd0;
        end
        else
        begin
            chain_reg   <= chain_next;
            counter_reg <= counter_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        mvalid_reg <= mvalid_next;
    end

    assign digest_word = chain_reg[{1'b0, cmd.word_sel}];

endmodule

/* hdl/b2b_ctrl.sv */
// ----------------------------------------------------------------------------
// b2b_ctrl
// sequencer for buffering, compression rounds and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2b_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          last,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    word_index,
    output logic          last_word,
    input  b2b_pkg::sts_t sts,
    output b2b_pkg::cmd_t cmd
);

    b2b_pkg::state_t state_reg, state_next;
    logic       last_reg, last_next;
    logic       final_reg, final_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [2:0] g_reg, g_next;
    logic [2:0] ph_reg, ph_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2b_pkg::S_IDLE;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
            rnd_reg   <= 4'd0;
            g_reg     <= 3'd0;
            ph_reg    <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            final_reg <= final_next;
            rnd_reg   <= rnd_next;
            g_reg     <= g_next;
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        final_next = final_reg;
        rnd_next   = rnd_reg;
        g_next     = g_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.op        = b2b_pkg::OP_NONE;
        cmd.take      = 1'b0;
        cmd.final_blk = final_reg;
        cmd.rnd       = rnd_reg;
        cmd.g         = g_reg;
        cmd.phase     = ph_reg;
        cmd.word_sel  = idx_reg;
        unique case (state_reg)
            b2b_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    last_next  = last;
                    state_next = b2b_pkg::S_DISPATCH;
                end
            end
            b2b_pkg::S_DISPATCH:
            begin
                if (!sts.count_zero && sts.fill_full)
                begin
                    // full buffer must go out before new bytes land
                    final_next = 1'b0;
                    state_next = b2b_pkg::S_COUNT;
                end
                else
                begin
                    if (!sts.count_zero)
                    begin
                        cmd.op = b2b_pkg::OP_WRITE;
                    end
                    if (last_reg)
                    begin
                        final_next = 1'b1;
                        state_next = b2b_pkg::S_COUNT;
                    end
                    else
                    begin
                        state_next = b2b_pkg::S_IDLE;
                    end
                end
            end
            b2b_pkg::S_COUNT:
            begin
                cmd.op     = b2b_pkg::OP_COUNT;
                state_next = b2b_pkg::S_INIT;
            end
            b2b_pkg::S_INIT:
            begin
                cmd.op     = b2b_pkg::OP_INIT;
                rnd_next   = 4'd0;
                g_next     = 3'd0;
                ph_next    = 3'd0;
                state_next = b2b_pkg::S_ROUND;
            end
            b2b_pkg::S_ROUND:
            begin
                cmd.op = b2b_pkg::OP_ROUND;
                if (ph_reg == 3'd4)
                begin
                    ph_next = 3'd0;
                    g_next  = g_reg + 3'd1;
                    if (g_reg == 3'd7)
                    begin
                        if (rnd_reg == 4'(b2b_pkg::ROUNDS - 1))
                        begin
                            state_next = b2b_pkg::S_FOLD;
                        end
                        else
                        begin
                            rnd_next = rnd_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            b2b_pkg::S_FOLD:
            begin
                cmd.op   = b2b_pkg::OP_FOLD;
                idx_next = 2'd0;
                if (final_reg)
                begin
                    state_next = b2b_pkg::S_OUT;
                end
                else
                begin
                    state_next = b2b_pkg::S_DISPATCH;
                end
            end
            b2b_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        cmd.op     = b2b_pkg::OP_RESET;
                        state_next = b2b_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = b2b_pkg::S_IDLE;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 2'd3);

endmodule

/* hdl/blake2b_256_hasher_core.sv */
// ----------------------------------------------------------------------------
// blake2b_256_hasher_core: unkeyed blake2b, 32-byte digest, word stream in;
// the next word is taken only once the last one is dispatched, and none while
// a block compresses (count, init, 12 rounds x 8 mixes x 5 steps, fold on
// one mixing unit); async active-low reset restores the initial chain value,
// zero counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blake2b_256_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    // message word transactions
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    // digest word transactions, four per message
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    // command and status bundles between sequencer and datapath
    b2b_pkg::cmd_t cmd;
    b2b_pkg::sts_t sts;

    // sequencer: accepts a word, decides whether a flush must run first,
    // steps rounds / mixes / phases, then presents the four digest words
    b2b_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .last_word  (last_word),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: block buffer ram, work vector, chain value, byte counter
    b2b_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .sts         (sts),
        .digest_word (digest_word)
    );

endmodule

/* hdl/b2b_checker.sv */
// ----------------------------------------------------------------------------
// b2b_checker
// port-level checks for the blake2b-256 core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b2b_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    // digest output and input intake never overlap
    `AST_SAME(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // final flag marks exactly the fourth word
    `AST_SAME(a_last_flag, clk, rst_n, out_valid, last_word == (word_index == 2'd3))
    // digest words come back to back in order
    `AST_NEXT(a_word_seq, clk, rst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 2'd1)
    // after the last digest word the core is ready for a new message
    `AST_NEXT(a_done_ready, clk, rst_n, out_valid && out_ready && last_word, in_ready && !out_valid)
    // a stalled digest word holds
    `AST_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word))

endmodule

bind blake2b_256_hasher_core b2b_checker u_b2b_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: blake2b-256 hasher core
// streams random and directed messages into the core and checks every digest
// word against a bit-true blake2b-256 model held in a small scoreboard class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// digest model and expected-word queue
class digest_board;
    logic [63:0] h [0:7];
    logic [63:0] cnt_lo, cnt_hi;
    logic [63:0] blk [0:15];
    int unsigned fill;
    logic [63:0] exp_word [$];
    logic [1:0]  exp_idx [$];
    logic        exp_lastw [$];
    int errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        h = b2b_pkg::IV;
        h[0] = h[0] ^ b2b_pkg::PARAM_WORD;
        cnt_lo = '0;
        cnt_hi = '0;
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = 0;
    endfunction

    function void bump(logic [63:0] n);
        cnt_lo = cnt_lo + n;
        if (cnt_lo < n) cnt_hi = cnt_hi + 1;
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void compress(bit fin);
        logic [63:0] v [0:15];
        int a, b, c, d;
        logic [63:0] x, y;
        for (int i = 0; i < 8; i++) begin
            v[i] = h[i];
            v[i + 8] = b2b_pkg::IV[i];
        end
        v[12] ^= cnt_lo;
        v[13] ^= cnt_hi;
        if (fin) v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
                // columns then diagonals
                a = g % 4;
                b = 4 + ((g % 4) + (g / 4)) % 4;
                c = 8 + ((g % 4) + 2 * (g / 4)) % 4;
                d = 12 + ((g % 4) + 3 * (g / 4)) % 4;
                x = blk[b2b_pkg::SIGMA[r][2 * g]];
                y = blk[b2b_pkg::SIGMA[r][2 * g + 1]];
                v[a] = v[a] + v[b] + x;
                v[d] = rotr(v[d] ^ v[a], 32);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 24);
                v[a] = v[a] + v[b] + y;
                v[d] = rotr(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 63);
            end
        end
        for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i + 8];
    endfunction

    // note one accepted message word
    function void note_word(logic [63:0] w, logic [3:0] bc, logic lst);
        int unsigned n;
        n = lst ? ((bc > 8) ? 8 : bc) : 8;
        if (n > 0) begin
            if (fill >= 128) begin
                bump(64'd128);
                compress(0);
                fill = 0;
            end
            if (n < 8) w = w & ((64'd1 << (n * 8)) - 1);
            blk[(fill >> 3) & 15] = w;
            fill += n;
        end
        if (!lst) return;
        bump(64'(fill));
        for (int k = (fill + 7) >> 3; k < 16; k++) blk[k] = '0;
        compress(1);
        for (int k = 0; k < 4; k++) begin
            exp_word.push_back(h[k]);
            exp_idx.push_back(2'(k));
            exp_lastw.push_back(k == 3);
        end
        restart();
    endfunction

    // check one accepted digest word
    function void check_word(logic [63:0] w, logic [1:0] idx, logic lw);
        if (exp_word.size() == 0) begin
            $error("digest word with nothing expected: %h", w);
            errors++;
            return;
        end
        if (w !== exp_word[0]) begin
            $error("digest_word expected %h actual %h", exp_word[0], w);
            errors++;
        end
        if (idx !== exp_idx[0]) begin
            $error("word_index expected %0d actual %0d", exp_idx[0], idx);
            errors++;
        end
        if (lw !== exp_lastw[0]) begin
            $error("last_word expected %0d actual %0d", exp_lastw[0], lw);
            errors++;
        end
        void'(exp_word.pop_front());
        void'(exp_idx.pop_front());
        void'(exp_lastw.pop_front());
    endfunction
endclass

module tb;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [63:0] data_word = '0;
    logic [3:0]  byte_count = '0;
    logic        last = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    digest_board board = new();
    bit quiet_mode = 0;       // no idling on either side
    bit hold_off = 0;         // receiver long stall request
    bit stim_done = 0;

    blake2b_256_hasher_core DUT (.*);

    always #4 clk = ~clk;

    // one message word transaction, driven on the falling edge
    task automatic send_word(logic [63:0] w, logic [3:0] bc, logic lst);
        while (!quiet_mode && $urandom_range(99) < 6) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        data_word <= w;
        byte_count <= bc;
        last <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_word(w, bc, lst);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // a message of nwords full words plus a last word of tail bytes
    task automatic send_msg(int nwords, logic [3:0] tail);
        for (int i = 0; i < nwords; i++)
            send_word(rnd64(), 4'($urandom), 0);
        send_word(rnd64(), tail, 1);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ready = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ready <= 0;
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            out_ready <= quiet_mode || ($urandom_range(99) >= 6);
        end
    end

    // monitor: sample at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_word(digest_word, word_index, last_word);

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty message, byte count saturation, field extremes
        send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1);
        send_word(64'h0, 4'd8, 1);
        send_word(64'h0123_4567_89ab_cdef, 4'd3, 1);
        // exactly one full block, then a zero-byte last: no extra compression
        for (int i = 0; i < 16; i++) send_word(~64'(i), 4'd0, 0);
        send_word(rnd64(), 4'd0, 1);
        // one block plus one byte forces a flush
        send_msg(16, 4'd1);

        // long receiver stall while messages keep coming
        hold_off = 1;
        for (int m = 0; m < 6; m++) send_msg(0, 4'($urandom_range(8)));

        // random messages, one stretch without idling
        for (int m = 0; m < 45; m++) begin
            quiet_mode = (m >= 15 && m < 25);
            if ($urandom_range(9) == 0) send_msg($urandom_range(17, 34), 4'($urandom));
            else send_msg($urandom_range(0, 6), 4'($urandom));
        end
        quiet_mode = 0;
        in_valid <= 0;

        wait (board.exp_word.size() == 0);
        repeat (600) @(posedge clk);
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #8ms;
        $display("tb: errors");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/b2b_pkg.sv
hdl/b2b_ram.sv
hdl/b2b_datapath.sv
hdl/b2b_ctrl.sv
hdl/blake2b_256_hasher_core.sv
hdl/b2b_checker.sv
test/tb.sv
